// File: rtl/sgain_pkg.sv
// Package for the stereo smoothed gain core: shared constants, the dB table
// build factors, state machine encodings and the command structs.
// No dependencies.
`default_nettype none

package sgain_pkg;

    localparam int LEVEL_W   = 11;
    localparam int COEF_W    = 16;
    localparam int TABLE_LEN = 1141;
    localparam int TBL_IDX_W = 11;
    localparam int TBL_FRAC  = 28;
    localparam int TBL_W     = 32;
    localparam int STEP_SH   = 16;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd1352;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -11'sd900;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 11'sd240;

    localparam logic [TBL_IDX_W-1:0] IDX_UNITY  = 11'd900;
    localparam logic [TBL_IDX_W-1:0] IDX_TOP    = 11'd1140;
    localparam logic [TBL_IDX_W-1:0] IDX_BOTTOM = 11'd1;

    localparam logic [28:0] UP_Q28   = 29'd271543792;
    localparam logic [28:0] DOWN_Q28 = 29'd265362701;
    localparam logic [TBL_W-1:0] UNITY_Q28 = 32'h1000_0000;

    typedef enum logic [1:0] {
        TI_UP,
        TI_DOWN,
        TI_DONE
    } sg_init_state_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_TARGET,
        ST_STEP_MUL,
        ST_STEP_ADD,
        ST_SCALE,
        ST_SAT,
        ST_OUT
    } sg_state_t;

    typedef struct packed {
        logic load_target;
        logic step_mul;
        logic step_add;
        logic advance;
    } sg_gain_cmd_t;

    typedef struct packed {
        logic mul_en;
        logic sat_en;
    } sg_lane_cmd_t;

endpackage

`default_nettype wire

// File: rtl/sgain_table.sv
// Level-to-gain lookup memory, filled after reset by a multiply sweep that
// walks up and down from unity in Q4.28. Depends on sgain_pkg.
`default_nettype none

module sgain_table
    import sgain_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [TBL_IDX_W-1:0]        rd_idx,
    output logic      [GAIN_FRAC_BITS+3:0]   rd_data,
    output logic                             ready
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 4;
    localparam int SH     = TBL_FRAC - GAIN_FRAC_BITS;
    localparam logic [TBL_W:0] HALF = ((TBL_W+1)'(1) << SH) >> 1;

    logic [GAIN_W-1:0] mem [TABLE_LEN];

    sg_init_state_t       state_reg, state_next;
    logic [TBL_W-1:0]     v_reg, v_next;
    logic [TBL_IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [GAIN_W-1:0]    rd_data_reg;

    logic [28:0]          factor;
    logic [60:0]          prod;
    logic [60:0]          prod_rnd;
    logic [TBL_W-1:0]     v_step;
    logic [TBL_W:0]       v_half;
    logic [GAIN_W-1:0]    entry;

    assign factor   = (state_reg == TI_UP) ? UP_Q28 : DOWN_Q28;
    assign prod     = 61'(v_reg) * 61'(factor);
    assign prod_rnd = prod + (61'd1 << (TBL_FRAC - 1));
    assign v_step   = prod_rnd[TBL_FRAC+TBL_W-1:TBL_FRAC];
    assign v_half   = {1'b0, v_reg} + HALF;
    assign entry    = GAIN_W'(v_half >> SH);

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        wr_idx_next = wr_idx_reg;
        case (state_reg)
            TI_UP:
            begin
                v_next      = v_step;
                wr_idx_next = wr_idx_reg + 1'b1;
                if (wr_idx_reg == IDX_TOP)
                begin
                    state_next  = TI_DOWN;
                    v_next      = TBL_W'(DOWN_Q28);
                    wr_idx_next = IDX_UNITY - 1'b1;
                end
            end
            TI_DOWN:
            begin
                v_next      = v_step;
                wr_idx_next = wr_idx_reg - 1'b1;
                if (wr_idx_reg == IDX_BOTTOM)
                begin
                    state_next = TI_DONE;
                end
            end
            TI_DONE:
            begin
                state_next = TI_DONE;
            end
            default:
            begin
                state_next = TI_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TI_UP;
            v_reg      <= UNITY_Q28;
            wr_idx_reg <= IDX_UNITY;
        end
        else
        begin
            state_reg  <= state_next;
            v_reg      <= v_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != TI_DONE)
        begin
            mem[wr_idx_reg] <= entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
    assign ready   = (state_reg == TI_DONE);

endmodule

`default_nettype wire

// File: rtl/sgain_gain.sv
// Gain state: target and held gain, the jump test at a period start, the
// chunk position counter and the one-pole step. Depends on sgain_pkg.
`default_nettype none

module sgain_gain
    import sgain_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20,
    parameter int CHUNK_FRAMES   = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sg_gain_cmd_t              cmd,
    input  wire logic [GAIN_FRAC_BITS+3:0] tbl_data,
    input  wire logic                      level_zero,
    input  wire logic [COEF_W-1:0]         coef,
    output logic      [GAIN_FRAC_BITS+3:0] gain
);

    localparam int GAIN_W  = GAIN_FRAC_BITS + 4;
    localparam int PHASE_W = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;
    localparam int PROD_W  = COEF_W + GAIN_W + 2;
    localparam int SUM_W   = PROD_W - STEP_SH;
    localparam longint LIMIT = ((longint'(1) << GAIN_FRAC_BITS) - 1) / 100;
    localparam logic [GAIN_W-1:0]  JUMP_LIMIT = GAIN_W'(LIMIT);
    localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CHUNK_FRAMES - 1);
    localparam logic signed [PROD_W-1:0] STEP_HALF = PROD_W'(1) <<< (STEP_SH - 1);
    localparam logic signed [SUM_W-1:0]  GMAX = SUM_W'({GAIN_W{1'b1}});

    logic [GAIN_W-1:0]         current_reg, current_next;
    logic [GAIN_W-1:0]         target_reg, target_next;
    logic                      active_reg, active_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic signed [PROD_W-1:0]  prod_reg;

    logic [GAIN_W-1:0]         new_target;
    logic [GAIN_W-1:0]         diff;
    logic                      step_due;
    logic signed [GAIN_W:0]    delta;
    logic signed [COEF_W:0]    coef_s;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [SUM_W-1:0]   step_val;
    logic signed [SUM_W-1:0]   sum;

    assign new_target = level_zero ? '0 : tbl_data;
    assign diff       = (current_reg > new_target) ? (current_reg - new_target)
                                                   : (new_target - current_reg);
    assign step_due   = active_reg && (phase_reg == '0);
    assign delta      = $signed({1'b0, target_reg}) - $signed({1'b0, current_reg});
    assign coef_s     = $signed({1'b0, coef});
    assign prod_full  = PROD_W'(coef_s) * PROD_W'(delta);
    assign prod_rnd   = prod_reg + STEP_HALF;
    assign step_val   = prod_rnd[PROD_W-1:STEP_SH];
    assign sum        = $signed(SUM_W'({1'b0, current_reg})) + step_val;

    always_comb
    begin
        current_next = current_reg;
        target_next  = target_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        if (cmd.load_target)
        begin
            target_next = new_target;
            phase_next  = '0;
            if (diff <= JUMP_LIMIT)
            begin
                current_next = new_target;
                active_next  = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
            end
        end
        if (cmd.step_add && step_due)
        begin
            if (sum < 0)
            begin
                current_next = '0;
            end
            else if (sum > GMAX)
            begin
                current_next = GAIN_W'(GMAX);
            end
            else
            begin
                current_next = GAIN_W'(sum);
            end
        end
        if (cmd.advance)
        begin
            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= '0;
            target_reg  <= GAIN_ONE;
            active_reg  <= 1'b0;
            phase_reg   <= '0;
        end
        else
        begin
            current_reg <= current_next;
            target_reg  <= target_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_mul)
        begin
            prod_reg <= prod_full;
        end
    end

    assign gain = current_reg;

endmodule

`default_nettype wire

// File: rtl/sgain_lane.sv
// One channel lane: sample times gain, then rounding to nearest with ties
// upward and saturation to the sample width. Depends on sgain_pkg.
`default_nettype none

module sgain_lane
    import sgain_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  wire logic                           clk,
    input  wire sg_lane_cmd_t                   cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]  sample,
    input  wire logic [GAIN_FRAC_BITS+3:0]      gain,
    output logic signed      [SAMPLE_BITS-1:0]  result
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 4;
    localparam int P_W    = SAMPLE_BITS + GAIN_W + 1;
    localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (GAIN_FRAC_BITS - 1);
    localparam logic signed [P_W-1:0] HI =
        P_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P_W-1:0] LO = -HI - P_W'(1);

    logic signed [P_W-1:0]         prod_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic signed [P_W-1:0]         prod;
    logic signed [P_W-1:0]         shifted;
    logic signed [SAMPLE_BITS-1:0] sat;

    assign prod    = P_W'(sample) * P_W'($signed({1'b0, gain}));
    assign shifted = (prod_reg + HALF) >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (shifted > HI)
        begin
            sat = HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < LO)
        begin
            sat = LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod;
        end
        if (cmd.sat_en)
        begin
            result_reg <= sat;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/stereo_smoothed_gain_core.sv
// Stereo volume stage with a smoothed gain; top level with the sequencer and
// the output register. Depends on sgain_pkg, sgain_table, sgain_gain and sgain_lane.
//
// Each transaction carries one stereo frame. A frame goes from acceptance to
// the output register through the sequencer states, and at a period start it
// also passes ST_LOOKUP and ST_TARGET, because the level must first be read
// from the gain table memory; the sequencer steps one frame at a time through
// the table read, the gain step and the multiply and saturate in both lanes.
// The next frame can be accepted in the cycle after the output register is
// loaded; a finished frame waits in ST_OUT while a stalled result still holds
// the output register. A new frame is accepted while the previous result still
// waits in the output register. After reset the table is built by a sweep,
// during which in_stall stays high; cfg_we is taken at any time. The gain is
// unsigned Q4.GAIN_FRAC_BITS and starts at zero, so frames before the first
// period start come out silent.
`default_nettype none

module stereo_smoothed_gain_core
    import sgain_pkg::*;
#(
    parameter int CHUNK_FRAMES   = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [COEF_W-1:0]             cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
    input  wire logic                          period_start,
    input  wire logic signed [LEVEL_W-1:0]     level_tenth_db,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed      [SAMPLE_BITS-1:0] left_out,
    output logic signed      [SAMPLE_BITS-1:0] right_out
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 4;

    sg_state_t                 state_reg, state_next;
    logic [COEF_W-1:0]         coef_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic                      level_zero_reg;
    logic [TBL_IDX_W-1:0]      idx_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    logic                      accept;
    logic                      out_load;
    logic                      out_free;
    logic                      tbl_ready;
    logic [GAIN_W-1:0]         tbl_data;
    logic [GAIN_W-1:0]         gain;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;
    logic                      level_zero;
    logic signed [LEVEL_W-1:0] level_clamped;
    logic signed [LEVEL_W:0]   level_offset;
    logic [TBL_IDX_W-1:0]      level_idx;
    sg_gain_cmd_t              gain_cmd;
    sg_lane_cmd_t              lane_cmd;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign level_zero    = (level_tenth_db <= LEVEL_MIN);
    assign level_clamped = (level_tenth_db > LEVEL_MAX) ? LEVEL_MAX : level_tenth_db;
    assign level_offset  = (LEVEL_W+1)'(level_clamped) - (LEVEL_W+1)'(LEVEL_MIN);
    assign level_idx     = level_zero ? IDX_UNITY : level_offset[TBL_IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        gain_cmd   = '0;
        lane_cmd   = '0;
        out_load   = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                if (tbl_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = period_start ? ST_LOOKUP : ST_STEP_MUL;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                gain_cmd.load_target = 1'b1;
                state_next           = ST_STEP_MUL;
            end
            ST_STEP_MUL:
            begin
                gain_cmd.step_mul = 1'b1;
                state_next        = ST_STEP_ADD;
            end
            ST_STEP_ADD:
            begin
                gain_cmd.step_add = 1'b1;
                state_next        = ST_SCALE;
            end
            ST_SCALE:
            begin
                lane_cmd.mul_en = 1'b1;
                state_next      = ST_SAT;
            end
            ST_SAT:
            begin
                lane_cmd.sat_en = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    gain_cmd.advance = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
            coef_reg      <= COEF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                coef_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg       <= left_sample;
            right_reg      <= right_sample;
            level_zero_reg <= level_zero;
            idx_reg        <= level_idx;
        end
        if (out_load)
        begin
            left_out_reg  <= left_res;
            right_out_reg <= right_res;
        end
    end

    sgain_table #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .rd_data (tbl_data),
        .ready   (tbl_ready)
    );

    sgain_gain #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .CHUNK_FRAMES   (CHUNK_FRAMES)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (gain_cmd),
        .tbl_data   (tbl_data),
        .level_zero (level_zero_reg),
        .coef       (coef_reg),
        .gain       (gain)
    );

    sgain_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_left (
        .clk    (clk),
        .cmd    (lane_cmd),
        .sample (left_reg),
        .gain   (gain),
        .result (left_res)
    );

    sgain_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_right (
        .clk    (clk),
        .cmd    (lane_cmd),
        .sample (right_reg),
        .gain   (gain),
        .result (right_res)
    );

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    // Only one frame is in flight between acceptance and the output register.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input accepted while a frame is still in flight");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("output valid raised outside the output state");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished frame not moved to the output register");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        !tbl_ready |-> in_stall)
        else $error("input accepted before the gain table was built");

endmodule

`default_nettype wire
